// ===== hw/rtl/ilir_pkg.sv =====
`timescale 1ns / 1ps

package ilir_pkg;

    localparam int OPCODE_W = 3;
    localparam int INDEX_W = 7;
    localparam int DATA_W = 32;
    localparam int STATUS_W = 2;
    localparam int LENGTH_W = 7;

    localparam int DEFAULT_DEPTH = 64;
    localparam int DEFAULT_ELEMENT_WIDTH = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE  = 3'd0,
        OP_READ   = 3'd1,
        OP_REMOVE = 3'd2,
        OP_INSERT = 3'd3,
        OP_PUSH   = 3'd4,
        OP_POP    = 3'd5,
        OP_CLEAR  = 3'd6,
        OP_NOP    = 3'd7
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_INDEX = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [INDEX_W-1:0]  index;
        logic [DATA_W-1:0]   element_data;
    } t_in_req;

    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic [STATUS_W-1:0] status;
        logic [LENGTH_W-1:0] length_now;
    } t_out_req;

    typedef struct packed {
        logic load_en;
        logic up_en;
        logic down_en;
    } t_cell_cmd;

endpackage

// ===== hw/rtl/ilir_cell.sv =====
`timescale 1ns / 1ps

module ilir_cell
    import ilir_pkg::*;
#(
    parameter int W   = DEFAULT_ELEMENT_WIDTH,
    parameter int PW  = 6,
    parameter int POS = 0
) (
    input  logic          i_clk,
    input  t_cell_cmd     i_cmd,
    input  logic [PW-1:0] i_pos,
    input  logic [W-1:0]  i_data,
    input  logic [W-1:0]  i_left,
    input  logic [W-1:0]  i_right,
    output logic [W-1:0]  o_value,
    output logic [W-1:0]  o_tap
);

    localparam logic [PW-1:0] MyPos = PW'(POS);

    logic [W-1:0] r_value;
    logic [W-1:0] n_value;
    logic         hit;

    assign hit = (i_pos == MyPos);

    always_comb begin
        n_value = r_value;
        if (i_cmd.load_en && hit) begin
            n_value = i_data;
        end else if (i_cmd.up_en && (MyPos > i_pos)) begin
            n_value = i_left;
        end else if (i_cmd.down_en && (MyPos >= i_pos)) begin
            n_value = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_tap   = hit ? r_value : '0;

endmodule

// ===== hw/rtl/indexed_list_insert_remove.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Valid       | Ready       | Payload
// in      | input     | i_in_valid  | o_in_ready  | i_in_data  (t_in_req)
// out     | output    | o_out_valid | i_out_ready | o_out_data (t_out_req)
//
// One request per cycle unless the output stalls: every operation, including
// insert and remove, is done at acceptance; the whole cell row shifts in parallel.
// The result appears in the output register in the cycle after acceptance.
// Reset clears the length and the output valid; cell contents stay undefined.
// A stalled output holds its result and blocks new requests until taken.

module indexed_list_insert_remove
    import ilir_pkg::*;
#(
    parameter int DEPTH         = DEFAULT_DEPTH,
    parameter int ELEMENT_WIDTH = DEFAULT_ELEMENT_WIDTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_data
);

    localparam int LW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = (LW > INDEX_W) ? LW : INDEX_W;
    localparam int XW = (ELEMENT_WIDTH > DATA_W) ? ELEMENT_WIDTH : DATA_W;

    logic [LW-1:0]        r_len;
    logic [LW-1:0]        n_len;
    logic                 r_out_valid;
    t_out_req             r_out;
    t_out_req             n_out;

    logic                 accept;
    t_op                  op;
    logic [CW-1:0]        idx_c;
    logic [CW-1:0]        len_c;
    logic [CW-1:0]        sel_pos;
    logic                 full;
    logic                 lt;
    logic                 le;
    logic                 rd_en;
    t_status              st;
    t_cell_cmd            cmd;
    t_cell_cmd            cell_cmd;
    logic [XW-1:0]        data_ext;
    logic [XW-1:0]        rd_ext;
    logic [CW-1:0]        n_len_c;

    logic [ELEMENT_WIDTH-1:0] values [DEPTH];
    logic [ELEMENT_WIDTH-1:0] taps   [DEPTH];
    logic [ELEMENT_WIDTH-1:0] tap_or;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign op    = t_op'(i_in_data.opcode);
    assign idx_c = CW'(i_in_data.index);
    assign len_c = CW'(r_len);
    assign full  = (r_len == LW'(DEPTH));
    assign lt    = (idx_c < len_c);
    assign le    = (idx_c <= len_c);

    always_comb begin
        sel_pos = idx_c;
        n_len   = r_len;
        st      = ST_OK;
        rd_en   = 1'b0;
        cmd     = '0;
        case (op)
            OP_WRITE: begin
                if (lt) begin
                    cmd.load_en = 1'b1;
                end else begin
                    st = ST_INDEX;
                end
            end
            OP_READ: begin
                if (lt) begin
                    rd_en = 1'b1;
                end else begin
                    st = ST_INDEX;
                end
            end
            OP_REMOVE: begin
                if (lt) begin
                    rd_en       = 1'b1;
                    cmd.down_en = 1'b1;
                    n_len       = r_len - LW'(1);
                end else begin
                    st = ST_INDEX;
                end
            end
            OP_INSERT: begin
                if (!le) begin
                    st = ST_INDEX;
                end else if (full) begin
                    st = ST_FULL;
                end else begin
                    cmd.load_en = 1'b1;
                    cmd.up_en   = 1'b1;
                    n_len       = r_len + LW'(1);
                end
            end
            OP_PUSH: begin
                sel_pos = len_c;
                if (full) begin
                    st = ST_FULL;
                end else begin
                    cmd.load_en = 1'b1;
                    cmd.up_en   = 1'b1;
                    n_len       = r_len + LW'(1);
                end
            end
            OP_POP: begin
                sel_pos = len_c - CW'(1);
                if (r_len == '0) begin
                    st = ST_INDEX;
                end else begin
                    rd_en = 1'b1;
                    n_len = r_len - LW'(1);
                end
            end
            OP_CLEAR: begin
                n_len = '0;
            end
            default: ;
        endcase
    end

    assign cell_cmd = accept ? cmd : '0;
    assign data_ext = XW'(i_in_data.element_data);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ELEMENT_WIDTH-1:0] left;
        logic [ELEMENT_WIDTH-1:0] right;

        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid
            assign left = values[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right = values[g];
        end else begin : g_inner
            assign right = values[g+1];
        end

        ilir_cell #(
            .W   (ELEMENT_WIDTH),
            .PW  (PW),
            .POS (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cell_cmd),
            .i_pos   (sel_pos[PW-1:0]),
            .i_data  (data_ext[ELEMENT_WIDTH-1:0]),
            .i_left  (left),
            .i_right (right),
            .o_value (values[g]),
            .o_tap   (taps[g])
        );
    end

    always_comb begin
        tap_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            tap_or = tap_or | taps[k];
        end
    end

    assign rd_ext  = XW'(tap_or);
    assign n_len_c = CW'(n_len);

    always_comb begin
        n_out.read_data  = rd_en ? rd_ext[DATA_W-1:0] : '0;
        n_out.status     = st;
        n_out.length_now = n_len_c[LENGTH_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_len       <= n_len;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(DEPTH))
        else $error("length above depth");

    a_fail_keeps_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (st != ST_OK) |=> $stable(r_len))
        else $error("failed request changed length");

    a_len_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.length_now == LENGTH_W'(CW'(r_len))))
        else $error("reported length differs from stored length");

    a_fail_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status != ST_OK) |-> (r_out.read_data == '0))
        else $error("failed request returned data");

    a_full_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && full && ((op == OP_INSERT) || (op == OP_PUSH)) |=> full)
        else $error("full list changed length on insert");

endmodule
